FILE: rtl/bas_pkg.sv
// Shared types and codes for the BCD add / subtract / multiply unit.
// No dependencies; used by every file under rtl.
package bas_pkg;

	// Fixed field geometry of the command and result words
	localparam int FIELD_DIGITS = 11;
	localparam int BCD_W        = 4 * FIELD_DIGITS;

	// Function codes
	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_SUB = 2'd1;
	localparam logic [1:0] FUNC_MUL = 2'd2;

	// Command word
	typedef struct packed {
		logic [1:0]       func;
		logic [BCD_W-1:0] operand_a;
		logic [BCD_W-1:0] operand_b;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic [BCD_W-1:0] result_bcd;
		logic [3:0]       digit_count;
		logic             overflow;
	} out_word_t;

	// Per-digit carry/borrow generate and propagate, lane to merge
	typedef struct packed {
		logic gen;
		logic prop;
	} gp_t;

endpackage

FILE: rtl/bas_digit_lane.sv
// One decimal digit lane: generate/propagate for the carry merge and the
// final digit once the incoming carry or borrow is known. Uses bas_pkg.
module bas_digit_lane (
	input  logic        [3:0] x,
	input  logic        [3:0] y,
	input  logic              sub,
	input  logic              cin,
	output bas_pkg::gp_t      gp,
	output logic        [3:0] digit
);
	import bas_pkg::*;

	logic [4:0] s;
	logic [4:0] t;
	logic [4:0] need;

	// add: carry out if x+y > 9, passes carry if x+y == 9
	// sub: borrow out if y > x, passes borrow if x == y
	always_comb begin
		s    = {1'b0, x} + {1'b0, y};
		t    = s + {4'd0, cin};
		need = {1'b0, y} + {4'd0, cin};
		if (sub) begin
			gp.gen  = (y > x);
			gp.prop = (x == y);
			if (need > {1'b0, x}) begin
				digit = 4'(({1'b0, x} + 5'd10) - need);
			end else begin
				digit = 4'({1'b0, x} - need);
			end
		end else begin
			gp.gen  = (s > 5'd9);
			gp.prop = (s == 5'd9);
			if (t > 5'd9) begin
				digit = 4'(t - 5'd10);
			end else begin
				digit = t[3:0];
			end
		end
	end

endmodule

FILE: rtl/bas_carry_merge.sv
// Parallel-prefix merge of the lanes' generate/propagate terms into the
// carry (or borrow) entering each digit. Uses bas_pkg.
module bas_carry_merge #(
	parameter int N = 11
) (
	input  bas_pkg::gp_t         gp [N],
	output logic         [N-1:0] carry,
	output logic                 cout
);
	import bas_pkg::*;

	localparam int L = (N > 1) ? $clog2(N) : 1;

	logic [N-1:0] gl [L+1];
	logic [N-1:0] pl [L+1];

	// Kogge-Stone prefix, ceil(log2(N)) levels
	always_comb begin
		for (int i = 0; i < N; i++) begin
			gl[0][i] = gp[i].gen;
			pl[0][i] = gp[i].prop;
		end
		for (int lv = 0; lv < L; lv++) begin
			for (int i = 0; i < N; i++) begin
				if (i >= (1 << lv)) begin
					gl[lv+1][i] = gl[lv][i] | (pl[lv][i] & gl[lv][i-(1 << lv)]);
					pl[lv+1][i] = pl[lv][i] & pl[lv][i-(1 << lv)];
				end else begin
					gl[lv+1][i] = gl[lv][i];
					pl[lv+1][i] = pl[lv][i];
				end
			end
		end
		carry[0] = 1'b0;
		for (int i = 1; i < N; i++) begin
			carry[i] = gl[L][i-1];
		end
		cout = gl[L][N-1];
	end

endmodule

FILE: rtl/bas_adder.sv
// N-digit BCD adder/subtractor: one lane per digit plus the carry merge.
// Depends on bas_pkg, bas_digit_lane and bas_carry_merge.
module bas_adder #(
	parameter int N = 11
) (
	input  logic [4*N-1:0] x,
	input  logic [4*N-1:0] y,
	input  logic           sub,
	output logic [4*N-1:0] sum,
	output logic           cout
);
	import bas_pkg::*;

	gp_t          gp [N];
	logic [N-1:0] carry;

	// digit lanes
	for (genvar g = 0; g < N; g++) begin : g_lane
		bas_digit_lane u_lane (
			.x     (x[4*g +: 4]),
			.y     (y[4*g +: 4]),
			.sub   (sub),
			.cin   (carry[g]),
			.gp    (gp[g]),
			.digit (sum[4*g +: 4])
		);
	end

	// carry/borrow resolution
	bas_carry_merge #(.N(N)) u_merge (
		.gp    (gp),
		.carry (carry),
		.cout  (cout)
	);

endmodule

FILE: rtl/bcd_add_sub_mul_unit_top.sv
// BCD add / subtract / multiply unit, top level.
// Depends on bas_pkg and bas_adder.
//
// Usage:
//   A command word (func, operand_a, operand_b) is taken at a rising edge with
//   start high and busy low. Operand nibbles 10 to 15 are read as 9.
//   The result word (result_bcd, digit_count, overflow) is shown for exactly
//   one cycle with done high; the receiver cannot hold it off.
//   Add and subtract: the lane adder result is registered in EXEC, then FIN
//   registers the result word and raises done.
//   Multiply: per digit of operand_b, most significant first, a shift step
//   then one pass through the same lane adder per unit of that digit's value.
//   Unused function code: result 0, count 1, no overflow.
//   busy is high from the accepting edge until the result word is out; a new
//   command may be taken in the cycle that done is high.
//   Overflow: carry beyond DIGITS digits, subtract borrow, or a product that
//   does not fit; the result wraps to DIGITS digits.
//   Reset clears the sequencer and the strobe; no word is pending afterwards.
module bcd_add_sub_mul_unit_top #(
	parameter int DIGITS = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bas_pkg::in_word_t  cmd,
	output logic               busy,
	output logic               done,
	output bas_pkg::out_word_t result
);
	import bas_pkg::*;

	localparam int ND    = (DIGITS < 2) ? 2 : ((DIGITS > 16) ? 16 : DIGITS);
	localparam int LD    = (ND < FIELD_DIGITS) ? ND : FIELD_DIGITS;
	localparam int IDX_W = $clog2(ND);
	localparam int W     = 4 * ND;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_ADD   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]       state_q;
	logic             done_q;
	logic [1:0]       func_q;
	logic [W-1:0]     a_q;
	logic [W-1:0]     b_q;
	logic [W-1:0]     r_q;
	logic             ov_q;
	logic [IDX_W-1:0] idx_q;
	logic [3:0]       k_q;
	out_word_t        res_q;

	logic [W-1:0]     a_in;
	logic [W-1:0]     b_in;
	logic [W-1:0]     add_x;
	logic [W-1:0]     add_y;
	logic             add_sub;
	logic [W-1:0]     add_sum;
	logic             add_cout;
	logic [3:0]       b_dig;
	logic [4:0]       cnt;
	logic [BCD_W-1:0] packed_r;

	// unpack operands: clamp invalid nibbles, digits beyond the field are zero
	always_comb begin
		a_in = '0;
		b_in = '0;
		for (int i = 0; i < LD; i++) begin
			a_in[4*i +: 4] = (cmd.operand_a[4*i +: 4] > 4'd9) ? 4'd9
			                                                  : cmd.operand_a[4*i +: 4];
			b_in[4*i +: 4] = (cmd.operand_b[4*i +: 4] > 4'd9) ? 4'd9
			                                                  : cmd.operand_b[4*i +: 4];
		end
	end

	// shared lane adder: a op b, or r + a while multiplying
	always_comb begin
		add_x   = (state_q == ST_ADD) ? r_q : a_q;
		add_y   = (state_q == ST_ADD) ? a_q : b_q;
		add_sub = (state_q != ST_ADD) && (func_q == FUNC_SUB);
	end

	bas_adder #(.N(ND)) u_adder (
		.x    (add_x),
		.y    (add_y),
		.sub  (add_sub),
		.sum  (add_sum),
		.cout (add_cout)
	);

	assign b_dig = b_q[4*idx_q +: 4];

	// significant digit count and packing of the result
	always_comb begin
		cnt = 5'd1;
		for (int i = 1; i < ND; i++) begin
			if (r_q[4*i +: 4] != 4'd0) begin
				cnt = 5'(i + 1);
			end
		end
		packed_r = '0;
		for (int i = 0; i < LD; i++) begin
			packed_r[4*i +: 4] = r_q[4*i +: 4];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= (cmd.func == FUNC_MUL) ? ST_SHIFT : ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
				end
				ST_SHIFT: begin
					if (b_dig != 4'd0) begin
						state_q <= ST_ADD;
					end else if (idx_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_ADD: begin
					if (k_q == 4'd1) begin
						state_q <= (idx_q == '0) ? ST_FIN : ST_SHIFT;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath words
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					func_q <= cmd.func;
					a_q    <= a_in;
					b_q    <= b_in;
					r_q    <= '0;
					ov_q   <= 1'b0;
					idx_q  <= IDX_W'(ND - 1);
				end
			end
			ST_EXEC: begin
				if (func_q == FUNC_ADD || func_q == FUNC_SUB) begin
					r_q  <= add_sum;
					ov_q <= add_cout;
				end
			end
			ST_SHIFT: begin
				if (r_q[W-1 -: 4] != 4'd0) begin
					ov_q <= 1'b1;
				end
				r_q <= {r_q[W-5:0], 4'd0};
				k_q <= b_dig;
				if (b_dig == 4'd0 && idx_q != '0) begin
					idx_q <= idx_q - 1'b1;
				end
			end
			ST_ADD: begin
				r_q  <= add_sum;
				ov_q <= ov_q | add_cout;
				k_q  <= k_q - 4'd1;
				if (k_q == 4'd1 && idx_q != '0) begin
					idx_q <= idx_q - 1'b1;
				end
			end
			ST_FIN: begin
				res_q.result_bcd  <= packed_r;
				res_q.digit_count <= cnt[3:0];
				res_q.overflow    <= ov_q;
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// a result word only ever follows a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_FIN)
		else $error("result word without a finished operation");

	// an accepted command always starts work
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command accepted but unit not busy");

	// repeated addition never runs with an exhausted count
	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> (k_q != 4'd0 && k_q <= 4'd9))
		else $error("multiply addition count out of range");

	// the digit index only moves down while multiplying
	a_idx_down: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && $past(state_q) == ST_SHIFT) |->
		(idx_q == $past(idx_q) - 1'b1))
		else $error("multiply digit index skipped");

endmodule
